### design/sols_pkg.sv
package sols_pkg;

  // Fixed field widths of the stream and configuration ports.
  localparam int unsigned PosW      = 10;
  localparam int unsigned KeyInW    = 20;
  localparam int unsigned CntW      = 16;
  localparam int unsigned PolicyW   = 2;
  localparam int unsigned LenW      = 11;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned InTdataW  = 32;
  localparam int unsigned InTuserW  = 1;
  localparam int unsigned OutTdataW = 16;

  localparam logic [CntW-1:0] CntMax = '1;

  localparam logic [CfgIdxW-1:0] CfgPolicy = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgLength = 1'd1;

  typedef enum logic [PolicyW-1:0] {
    POL_FIRST = 2'd0,
    POL_PRED  = 2'd1,
    POL_COUNT = 2'd2,
    POL_NONE  = 2'd3
  } policy_e;

  // Read address selection of both tables.
  typedef enum logic [1:0] {
    RSEL_SCAN = 2'd0,
    RSEL_HIT  = 2'd1,
    RSEL_PRED = 2'd2
  } rsel_e;

  // Write address selection of both tables.
  typedef enum logic [1:0] {
    WSEL_LOAD  = 2'd0,
    WSEL_CLEAR = 2'd1,
    WSEL_HIT   = 2'd2,
    WSEL_PRED  = 2'd3
  } wsel_e;

  typedef struct packed {
    logic  clr_step;
    logic  load_start;
    logic  scan_start;
    logic  scan_step;
    logic  hit_capture;
    logic  latch_hcnt;
    rsel_e rsel;
    wsel_e wsel;
    logic  key_we;
    logic  cnt_we;
    logic  cnt_take_pred;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic    clr_last;
    logic    is_search;
    logic    pos_ok;
    logic    match;
    logic    scan_end;
    logic    hit_zero;
    logic    cnt_gt;
    logic    out_free;
    policy_e policy;
  } status_t;

endpackage

### design/sols_ctrl.sv
module sols_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sols_pkg::status_t status_i,
  output sols_pkg::cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_SCAN  = 9'b000000100,
    ST_RD0   = 9'b000001000,
    ST_RD1   = 9'b000010000,
    ST_RD2   = 9'b000100000,
    ST_WRA   = 9'b001000000,
    ST_WRB   = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   swap_q, swap_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      swap_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      swap_q  <= swap_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    swap_d  = swap_q;
    cmd_o   = '0;
    cmd_o.rsel = sols_pkg::RSEL_SCAN;
    cmd_o.wsel = sols_pkg::WSEL_LOAD;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        cmd_o.cnt_we   = 1'b1;
        cmd_o.wsel     = sols_pkg::WSEL_CLEAR;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (status_i.is_search) begin
            cmd_o.scan_start = 1'b1;
            state_d = ST_SCAN;
          end else begin
            cmd_o.load_start = 1'b1;
            cmd_o.key_we     = status_i.pos_ok;
            cmd_o.cnt_we     = status_i.pos_ok;
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.match) begin
          cmd_o.hit_capture = 1'b1;
          state_d = ST_RD0;
        end else if (status_i.scan_end) begin
          state_d = ST_DONE;
        end
      end
      ST_RD0: begin
        cmd_o.rsel = sols_pkg::RSEL_HIT;
        state_d = ST_RD1;
      end
      ST_RD1: begin
        cmd_o.rsel       = sols_pkg::RSEL_PRED;
        cmd_o.latch_hcnt = 1'b1;
        state_d = ST_RD2;
      end
      ST_RD2: begin
        cmd_o.rsel = sols_pkg::RSEL_PRED;
        unique case (status_i.policy)
          sols_pkg::POL_FIRST: swap_d = !status_i.hit_zero;
          sols_pkg::POL_PRED:  swap_d = !status_i.hit_zero;
          sols_pkg::POL_COUNT: swap_d = !status_i.hit_zero && status_i.cnt_gt;
          sols_pkg::POL_NONE:  swap_d = 1'b0;
          default:             swap_d = 1'b0;
        endcase
        state_d = ST_WRA;
      end
      ST_WRA: begin
        // The hit position takes the predecessor's entry when swapping.
        cmd_o.rsel          = sols_pkg::RSEL_PRED;
        cmd_o.wsel          = sols_pkg::WSEL_HIT;
        cmd_o.key_we        = swap_q;
        cmd_o.cnt_we        = (status_i.policy == sols_pkg::POL_COUNT);
        cmd_o.cnt_take_pred = swap_q;
        state_d = ST_WRB;
      end
      ST_WRB: begin
        cmd_o.rsel   = sols_pkg::RSEL_PRED;
        cmd_o.wsel   = sols_pkg::WSEL_PRED;
        cmd_o.key_we = swap_q;
        cmd_o.cnt_we = swap_q && (status_i.policy == sols_pkg::POL_COUNT);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

### design/sols_dp.sv
module sols_dp #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned KEY_WIDTH   = 20
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [sols_pkg::InTdataW-1:0]    in_tdata_i,
  input  logic [sols_pkg::InTuserW-1:0]    in_tuser_i,
  output logic                             out_tvalid_o,
  input  logic                             out_tready_i,
  output logic [sols_pkg::OutTdataW-1:0]   out_tdata_o,
  input  logic                             cfg_write_i,
  input  logic [sols_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [sols_pkg::LenW-1:0]        cfg_data_i,
  input  sols_pkg::cmd_t                   cmd_i,
  output sols_pkg::status_t                status_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned PosW = sols_pkg::PosW;
  localparam int unsigned CntW = sols_pkg::CntW;

  logic [KEY_WIDTH-1:0] key_mem [TABLE_DEPTH];
  logic [CntW-1:0]      cnt_mem [TABLE_DEPTH];

  // Configuration registers.
  sols_pkg::policy_e         policy_q;
  logic [sols_pkg::LenW-1:0] len_cfg_q;

  // Control registers.
  logic [AW-1:0] clr_idx_q;
  logic          cmp_vld_q;
  logic          out_vld_q;

  // Payload registers.
  logic [CW-1:0]        rd_idx_q, cmp_idx_q, len_q;
  logic [KEY_WIDTH-1:0] key_q, rd_key_q;
  logic [CntW-1:0]      rd_cnt_q, new_cnt_q;
  logic [AW-1:0]        hit_q;
  logic                 res_found_q;
  logic [PosW-1:0]      res_pos_q;
  logic [sols_pkg::OutTdataW-1:0] out_data_q;

  logic [PosW-1:0]           in_pos;
  logic [KEY_WIDTH-1:0]      in_key;
  logic [CW-1:0]             len_sat;
  logic [AW-1:0]             pred_idx;
  logic [AW-1:0]             key_raddr, cnt_raddr, waddr;
  logic [KEY_WIDTH-1:0]      wkey;
  logic [CntW-1:0]           wcnt;
  logic [CntW-1:0]           cnt_inc;

  assign in_pos = in_tdata_i[PosW-1:0];
  assign in_key = KEY_WIDTH'(in_tdata_i[PosW +: sols_pkg::KeyInW]);

  assign len_sat = (32'(len_cfg_q) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(len_cfg_q);

  assign pred_idx = (policy_q == sols_pkg::POL_FIRST) ? '0 : hit_q - AW'(1);

  assign cnt_inc = (rd_cnt_q == sols_pkg::CntMax) ? rd_cnt_q : rd_cnt_q + CntW'(1);

  always_comb begin
    unique case (cmd_i.rsel)
      sols_pkg::RSEL_SCAN: begin
        key_raddr = rd_idx_q[AW-1:0];
        cnt_raddr = hit_q;
      end
      sols_pkg::RSEL_HIT: begin
        key_raddr = pred_idx;
        cnt_raddr = hit_q;
      end
      sols_pkg::RSEL_PRED: begin
        key_raddr = pred_idx;
        cnt_raddr = pred_idx;
      end
      default: begin
        key_raddr = pred_idx;
        cnt_raddr = pred_idx;
      end
    endcase
  end

  always_comb begin
    unique case (cmd_i.wsel)
      sols_pkg::WSEL_LOAD: begin
        waddr = AW'(in_pos);
        wkey  = in_key;
        wcnt  = '0;
      end
      sols_pkg::WSEL_CLEAR: begin
        waddr = clr_idx_q;
        wkey  = in_key;
        wcnt  = '0;
      end
      sols_pkg::WSEL_HIT: begin
        waddr = hit_q;
        wkey  = rd_key_q;
        wcnt  = cmd_i.cnt_take_pred ? rd_cnt_q : new_cnt_q;
      end
      sols_pkg::WSEL_PRED: begin
        waddr = pred_idx;
        wkey  = key_q;
        wcnt  = new_cnt_q;
      end
      default: begin
        waddr = hit_q;
        wkey  = key_q;
        wcnt  = new_cnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_we) begin
      key_mem[waddr] <= wkey;
    end
    rd_key_q <= key_mem[key_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_we) begin
      cnt_mem[waddr] <= wcnt;
    end
    rd_cnt_q <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q  <= sols_pkg::POL_FIRST;
      len_cfg_q <= '0;
      clr_idx_q <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_write_i && cfg_index_i == sols_pkg::CfgPolicy) begin
        policy_q <= sols_pkg::policy_e'(cfg_data_i[sols_pkg::PolicyW-1:0]);
      end
      if (cfg_write_i && cfg_index_i == sols_pkg::CfgLength) begin
        len_cfg_q <= cfg_data_i;
      end
      if (cmd_i.clr_step) begin
        clr_idx_q <= clr_idx_q + AW'(1);
      end
      if (cmd_i.scan_start) begin
        cmp_vld_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        cmp_vld_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      rd_idx_q <= '0;
      key_q    <= in_key;
      len_q    <= len_sat;
    end else if (cmd_i.scan_step) begin
      rd_idx_q  <= rd_idx_q + CW'(1);
      cmp_idx_q <= rd_idx_q;
    end
    if (cmd_i.scan_start || cmd_i.load_start) begin
      res_found_q <= 1'b0;
      res_pos_q   <= '0;
    end else if (cmd_i.hit_capture) begin
      res_found_q <= 1'b1;
      res_pos_q   <= PosW'(cmp_idx_q);
    end
    if (cmd_i.hit_capture) begin
      hit_q <= cmp_idx_q[AW-1:0];
    end
    if (cmd_i.latch_hcnt) begin
      new_cnt_q <= cnt_inc;
    end
    if (cmd_i.out_load) begin
      out_data_q <= sols_pkg::OutTdataW'({res_pos_q, res_found_q});
    end
  end

  assign out_tvalid_o = out_vld_q;
  assign out_tdata_o  = out_data_q;

  always_comb begin
    status_o.clr_last  = (clr_idx_q == AW'(TABLE_DEPTH - 1));
    status_o.is_search = in_tuser_i[0];
    status_o.pos_ok    = (32'(in_pos) < 32'(TABLE_DEPTH));
    status_o.match     = cmp_vld_q && (rd_key_q == key_q) && (cmp_idx_q < len_q);
    status_o.scan_end  = (len_q == '0) || (cmp_vld_q && (cmp_idx_q == len_q - CW'(1)));
    status_o.hit_zero  = (hit_q == '0);
    status_o.cnt_gt    = (new_cnt_q > rd_cnt_q);
    status_o.out_free  = !out_vld_q || out_tready_i;
    status_o.policy    = policy_q;
  end

endmodule

### design/self_organizing_list_search_core.sv
// Self-organising list search. Keys sit in a table with a hit count per entry.
// Input words arrive on the s_axis channel: tuser bit 0 selects load (0) or
// search (1); tdata carries the table position and the key. A load writes the
// key and clears the count at that position; a search scans positions 0 up to
// list_length-1 one table read per cycle, stops at the first match, and on a
// hit reorders the table by the configured policy. Results leave on m_axis,
// one word per input word. A search takes longer the later it hits or, on a
// miss, the longer the list length (clipped to TABLE_DEPTH); the sequential
// table scan through a single read port sets this.
// One item is in flight at a time; a new input word is taken as soon as the
// previous result sits in the output register, even while m_axis stalls.
// A stalled result word holds its value until taken; the block then waits.
// After reset the hit counts are cleared in a pass over all table entries,
// during which no input word is accepted; the key table is not initialised.
// Configuration writes (index 0 policy, index 1 list length) are always
// accepted and should be issued only while the block is idle.
module self_organizing_list_search_core #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned KEY_WIDTH   = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // entry_position [9:0], search_key [29:10], zero [31:30]
  input  logic [sols_pkg::InTdataW-1:0]  s_axis_tdata_i,
  // operation [0]
  input  logic [sols_pkg::InTuserW-1:0]  s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // found [0], hit_position [10:1], zero [15:11]
  output logic [sols_pkg::OutTdataW-1:0] m_axis_tdata_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sols_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sols_pkg::LenW-1:0]      cfg_data_i
);

  sols_pkg::cmd_t    cmd;
  sols_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  sols_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sols_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_tdata_i   (s_axis_tdata_i),
    .in_tuser_i   (s_axis_tuser_i),
    .out_tvalid_o (m_axis_tvalid_o),
    .out_tready_i (m_axis_tready_i),
    .out_tdata_o  (m_axis_tdata_o),
    .cfg_write_i  (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .status_o     (status)
  );

endmodule

### design/sols_checker.sv
module sols_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [sols_pkg::OutTdataW-1:0] m_axis_tdata_o
);

  // A result word that is not taken stays on the bus unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result word changed");

  // A miss or a load reports position zero, and the padding stays clear.
  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[15:1] == '0)
    else $error("miss reported a nonzero position");

  // The input side is closed in the cycle after a word is accepted.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second word accepted while one is in progress");

  // A new result only appears after the input side was closed for an item.
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o))
    else $error("result appeared without an item in progress");

endmodule

bind self_organizing_list_search_core sols_checker u_sols_checker (.*);

### test/self_organizing_list_search_core_test.sv
`timescale 1ns / 100ps

module self_organizing_list_search_core_test;
  import sols_pkg::*;

  localparam int unsigned Depth      = 1024;
  localparam int unsigned CycleLimit = 5_000_000;
  localparam int unsigned PhaseWords = 68;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] pos;
  } search_outcome_t;

  // Mirror of the key table and hit counts, updated in acceptance order.
  class list_mirror;
    logic [KeyInW-1:0] keys[Depth];
    logic [CntW-1:0]   counts[Depth];
    bit                loaded[Depth];
    policy_e           policy;
    logic [LenW-1:0]   length;
    search_outcome_t   expected_outcomes[$];
    int unsigned       failures;

    function new();
      for (int unsigned i = 0; i < Depth; i++) begin
        keys[i]   = '0;
        counts[i] = '0;
        loaded[i] = 1'b0;
      end
      policy   = POL_FIRST;
      length   = '0;
      failures = 0;
    endfunction

    function int unsigned eff_length();
      return (length > Depth) ? Depth : int'(length);
    endfunction

    // True when a search for this key touches only entries already loaded.
    function bit scan_safe(logic [KeyInW-1:0] key);
      int unsigned eff;
      eff = eff_length();
      for (int unsigned i = 0; i < eff; i++) begin
        if (!loaded[i]) return 1'b0;
        if (keys[i] == key) return 1'b1;
      end
      return 1'b1;
    endfunction

    function void note_config(logic [CfgIdxW-1:0] idx, logic [LenW-1:0] data);
      if (idx == CfgPolicy) begin
        policy = policy_e'(data[PolicyW-1:0]);
      end else begin
        length = data;
      end
    endfunction

    function void swap_keys(int unsigned a, int unsigned b);
      logic [KeyInW-1:0] k;
      k       = keys[a];
      keys[a] = keys[b];
      keys[b] = k;
    endfunction

    function void note_word(op_e op, logic [PosW-1:0] pos, logic [KeyInW-1:0] key);
      search_outcome_t outcome;
      int unsigned     eff;
      int unsigned     hit;
      logic [CntW-1:0] c;
      outcome = '0;
      if (op == OP_LOAD) begin
        keys[pos]   = key;
        counts[pos] = '0;
        loaded[pos] = 1'b1;
        expected_outcomes.push_back(outcome);
        return;
      end
      eff = eff_length();
      hit = eff;
      for (int unsigned i = 0; i < eff; i++) begin
        if (keys[i] == key) begin
          hit = i;
          break;
        end
      end
      if (hit < eff) begin
        outcome.found = 1'b1;
        outcome.pos   = hit[PosW-1:0];
        case (policy)
          POL_FIRST: begin
            if (hit != 0) swap_keys(hit, 0);
          end
          POL_PRED: begin
            if (hit != 0) swap_keys(hit, hit - 1);
          end
          POL_COUNT: begin
            if (counts[hit] != CntMax) counts[hit] = counts[hit] + 1'b1;
            if (hit != 0 && counts[hit] > counts[hit-1]) begin
              swap_keys(hit, hit - 1);
              c               = counts[hit];
              counts[hit]     = counts[hit-1];
              counts[hit-1]   = c;
            end
          end
          default: ;
        endcase
      end
      expected_outcomes.push_back(outcome);
    endfunction

    function void check_result(logic [OutTdataW-1:0] word);
      search_outcome_t exp_outcome;
      if (expected_outcomes.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result word %h", word);
        return;
      end
      exp_outcome = expected_outcomes.pop_front();
      if (word[0] !== exp_outcome.found || word[PosW:1] !== exp_outcome.pos ||
          word[OutTdataW-1:PosW+1] !== '0) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch: expected found %0d position %0d, got found %0d position %0d pad %h",
                   exp_outcome.found, exp_outcome.pos, word[0], word[PosW:1],
                   word[OutTdataW-1:PosW+1]);
        end
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [InTdataW-1:0]  s_axis_tdata_i;
  logic [InTuserW-1:0]  s_axis_tuser_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [OutTdataW-1:0] m_axis_tdata_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [LenW-1:0]      cfg_data_i;

  list_mirror  mirror;
  bit          in_idle;
  bit          out_idle;
  int unsigned cycle_count = 0;

  self_organizing_list_search_core dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) mirror.check_result(m_axis_tdata_o);
  end

  // Result side: a fresh random stall before every word while out_idle is set.
  initial begin
    int unsigned stall;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      stall = out_idle ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!(rst_ni && m_axis_tvalid_o));
    end
  end

  // Valid is left high on return; the caller either sends again or drains.
  task automatic send_word(op_e op, logic [PosW-1:0] pos, logic [KeyInW-1:0] key);
    int unsigned gap;
    gap = in_idle ? $urandom_range(0, 3) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {2'b00, key, pos};
    do @(posedge clk_i); while (!s_axis_tready_o);
    mirror.note_word(op, pos, key);
  endtask

  task automatic wait_until_idle();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (mirror.expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [LenW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    mirror.note_config(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_word();
    int unsigned       eff;
    logic [PosW-1:0]   pos;
    logic [KeyInW-1:0] key;
    eff = mirror.eff_length();
    if ($urandom_range(0, 9) >= 4) begin
      if (eff > 0 && $urandom_range(0, 3) != 0) key = mirror.keys[$urandom_range(0, eff - 1)];
      else key = KeyInW'($urandom);
      if (mirror.scan_safe(key)) begin
        send_word(OP_SEARCH, '0, key);
        return;
      end
    end
    if (eff > 0 && $urandom_range(0, 4) != 0) pos = PosW'($urandom_range(0, eff - 1));
    else pos = PosW'($urandom_range(0, Depth - 1));
    // Reusing a key already in the table exercises first-match ordering.
    if ($urandom_range(0, 1) != 0 && mirror.loaded[pos]) key = mirror.keys[$urandom_range(0, pos)];
    else key = KeyInW'($urandom);
    send_word(OP_LOAD, pos, key);
  endtask

  initial begin
    logic [LenW-1:0] len_value;
    mirror          = new();
    in_idle         = 1'b1;
    out_idle        = 1'b1;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // An empty list misses whatever the table holds.
    send_word(OP_SEARCH, '0, '0);
    send_word(OP_LOAD, 10'd0, '1);
    send_word(OP_LOAD, 10'd1, '0);
    send_word(OP_LOAD, 10'd2, 20'h12345);
    send_word(OP_LOAD, 10'd3, '1);
    send_word(OP_LOAD, '1, 20'h5a5a5);
    wait_until_idle();
    write_reg(CfgLength, 11'd4);
    write_reg(CfgPolicy, LenW'(POL_FIRST));
    send_word(OP_SEARCH, '0, 20'h12345);
    send_word(OP_SEARCH, '0, '1);
    send_word(OP_SEARCH, '0, 20'h00001);
    send_word(OP_SEARCH, '0, '1);
    wait_until_idle();
    write_reg(CfgPolicy, LenW'(POL_PRED));
    send_word(OP_SEARCH, '0, 20'h12345);
    send_word(OP_SEARCH, '0, '0);
    send_word(OP_SEARCH, '0, '0);
    wait_until_idle();
    write_reg(CfgPolicy, LenW'(POL_NONE));
    send_word(OP_SEARCH, '0, 20'h12345);
    send_word(OP_SEARCH, '0, '1);
    wait_until_idle();
    write_reg(CfgPolicy, LenW'(POL_COUNT));
    send_word(OP_SEARCH, '0, '0);
    send_word(OP_SEARCH, '0, '0);
    send_word(OP_SEARCH, '0, 20'h12345);
    send_word(OP_SEARCH, '0, 20'h12345);
    send_word(OP_SEARCH, '0, 20'h12345);
    wait_until_idle();
    // A length beyond the table is clipped; the hit comes early here.
    write_reg(CfgLength, '1);
    send_word(OP_SEARCH, '0, '1);

    for (int unsigned phase = 0; phase < 7; phase++) begin
      wait_until_idle();
      case (phase)
        0: len_value = LenW'($urandom_range(1, 16));
        1: len_value = '0;
        2: len_value = 11'd1024;
        3: len_value = 11'd2;
        4: len_value = LenW'($urandom_range(17, 200));
        5: len_value = '1;
        default: len_value = LenW'($urandom_range(0, 2047));
      endcase
      write_reg(CfgLength, len_value);
      // Upper data bits are don't-care for the policy register.
      write_reg(CfgPolicy, {(LenW - PolicyW)'($urandom), PolicyW'(phase % 4)});
      for (int unsigned n = 0; n < PhaseWords; n++) begin
        if (n % 24 == 0) begin
          in_idle  = ($urandom_range(0, 2) != 0);
          out_idle = ($urandom_range(0, 2) != 0);
        end
        random_word();
      end
    end

    wait_until_idle();
    repeat (20) @(posedge clk_i);
    if (mirror.failures == 0 && mirror.expected_outcomes.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
